// ----- design/apbo_pkg.sv -----
// types and constants shared by the pixel blend pipeline
package apbo_pkg;

   localparam logic [7:0] ALPHA_MAX   = 8'd255;
   localparam int unsigned CH_ALPHA   = 3;
   localparam int unsigned NUM_COLORS = 3;
   localparam int unsigned NUM_LANES  = 4;
   localparam int unsigned DIV_STAGES = 8;
   localparam int unsigned WGT_STAGES = 3;
   localparam int unsigned PIPE_DEPTH = WGT_STAGES + DIV_STAGES + 1;
   localparam int unsigned NUM_BITS   = 24;
   localparam int unsigned AL_BITS    = 16;

   localparam logic MODE_SOURCE = 1'b0;
   localparam logic MODE_OVER   = 1'b1;

   // bits 7:0 blue, 15:8 green, 23:16 red, 31:24 alpha
   typedef logic [NUM_LANES-1:0][7:0] pixel_type;

   typedef struct packed {
      logic                             use_blend;
      pixel_type                        pass_pixel;
      logic [NUM_COLORS-1:0][7:0]       src_rgb;
      logic [NUM_COLORS-1:0][7:0]       dst_rgb;
      logic [AL_BITS-1:0]               u;
      logic [AL_BITS-1:0]               v;
   } wgt_data_type;

   typedef struct packed {
      logic                             use_blend;
      pixel_type                        pass_pixel;
      logic [NUM_COLORS-1:0][NUM_BITS-1:0] su;
      logic [NUM_COLORS-1:0][NUM_BITS-1:0] dv;
      logic [AL_BITS-1:0]               al;
   } prod_data_type;

   typedef struct packed {
      logic                             use_blend;
      pixel_type                        pass_pixel;
      logic [NUM_COLORS-1:0][NUM_BITS-1:0] rem;
      logic [NUM_LANES-1:0][7:0]        quo;
      logic [AL_BITS-1:0]               al;
   } div_data_type;

endpackage

// ----- design/apbo_intf.sv -----
// valid/ready channel interfaces for the pixel blend unit
interface apbo_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] src_pixel;
   logic [31:0] dst_pixel;

   modport source (output valid, output src_pixel, output dst_pixel, input ready);
   modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface apbo_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;

   modport source (output valid, output out_pixel, input ready);
   modport sink   (input valid, input out_pixel, output ready);
endinterface

// ----- design/apng_pixel_blend_over_unit.sv -----
// top level of the straight-alpha "over" pixel blend unit
//
//  channel   direction  payload                      handshake
//  req_bus   in         src_pixel[31:0] dst_pixel    valid/ready
//  rsp_bus   out        out_pixel[31:0]              valid/ready
//  csr       in         csr_wr_data (blend mode)     write enable
//
// one beat per clock while the output is not stalled; 3 weight/product stages,
// 8 divider stages (one quotient bit each), 1 output register
// every stage loads when empty or when the stage after it moves, so bubbles
// collapse while the output stalls
// reset clears all valid bits and sets blend mode to over
module apng_pixel_blend_over_unit import apbo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   apbo_req_if.sink     req_bus,
   apbo_rsp_if.source   rsp_bus,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic         blend_mode_ff;
   logic         wgt_valid, wgt_ready;
   div_data_type wgt_data;
   logic         div_valid, div_ready;
   div_data_type div_data;
   logic         rsp_valid_ff;
   pixel_type    rsp_pixel_ff, rsp_pixel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= MODE_OVER;
      end else if (csr_wr_en) begin
         blend_mode_ff <= csr_wr_data;
      end
   end

   apbo_weight u_weight (
      .clock      (clock),
      .reset      (reset),
      .blend_mode (blend_mode_ff),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_src     (req_bus.src_pixel),
      .in_dst     (req_bus.dst_pixel),
      .out_valid  (wgt_valid),
      .out_ready  (wgt_ready),
      .out_data   (wgt_data)
   );

   apbo_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wgt_valid),
      .in_ready  (wgt_ready),
      .in_data   (wgt_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign div_ready    = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_pixel_in = div_data.use_blend ? div_data.quo : div_data.pass_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready && div_valid) rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_pixel = rsp_pixel_ff;

endmodule

// ----- design/apbo_weight.sv -----
// alpha weights, channel products and dividends: three pipeline stages
module apbo_weight import apbo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         blend_mode,
   input  logic         in_valid,
   output logic         in_ready,
   input  pixel_type    in_src,
   input  pixel_type    in_dst,
   output logic         out_valid,
   input  logic         out_ready,
   output div_data_type out_data
);

   logic          wgt_valid_ff, prod_valid_ff, sum_valid_ff;
   logic          wgt_ready, prod_ready, sum_ready;
   wgt_data_type  wgt_ff, wgt_in;
   prod_data_type prod_ff, prod_in;
   div_data_type  sum_ff, sum_in;
   logic [7:0]    sa, da, sa_inv;

   assign sum_ready  = !sum_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign wgt_ready  = !wgt_valid_ff || prod_ready;
   assign in_ready   = wgt_ready;

   assign sa     = in_src[CH_ALPHA];
   assign da     = in_dst[CH_ALPHA];
   assign sa_inv = ALPHA_MAX - sa;

   // stage 1: weights and the pass-through choice
   always_comb begin
      wgt_in.src_rgb    = in_src[NUM_COLORS-1:0];
      wgt_in.dst_rgb    = in_dst[NUM_COLORS-1:0];
      wgt_in.u          = {sa, 8'h00} - {8'h00, sa};
      wgt_in.v          = AL_BITS'(sa_inv) * AL_BITS'(da);
      wgt_in.use_blend  = 1'b0;
      wgt_in.pass_pixel = in_src;
      if (blend_mode == MODE_SOURCE) begin
         wgt_in.pass_pixel = in_src;
      end else if (sa == ALPHA_MAX) begin
         wgt_in.pass_pixel = in_src;
      end else if (sa == 8'd0) begin
         wgt_in.pass_pixel = in_dst;
      end else if (da == 8'd0) begin
         wgt_in.pass_pixel = in_src;
      end else begin
         wgt_in.use_blend = 1'b1;
      end
   end

   // stage 2: s*u, d*v and the divisor
   always_comb begin
      prod_in.use_blend  = wgt_ff.use_blend;
      prod_in.pass_pixel = wgt_ff.pass_pixel;
      prod_in.al         = wgt_ff.u + wgt_ff.v;
      for (int k = 0; k < NUM_COLORS; k++) begin
         prod_in.su[k] = NUM_BITS'(wgt_ff.src_rgb[k]) * NUM_BITS'(wgt_ff.u);
         prod_in.dv[k] = NUM_BITS'(wgt_ff.dst_rgb[k]) * NUM_BITS'(wgt_ff.v);
      end
   end

   // stage 3: dividends; the alpha lane divides the sum of weights by 255
   always_comb begin
      logic [AL_BITS-1:0] al_round;
      sum_in.use_blend  = prod_ff.use_blend;
      sum_in.pass_pixel = prod_ff.pass_pixel;
      sum_in.al         = prod_ff.al;
      sum_in.quo        = '0;
      for (int k = 0; k < NUM_COLORS; k++) begin
         sum_in.rem[k] = prod_ff.su[k] + prod_ff.dv[k];
      end
      // (al + al/256 + 1)/256 equals al/255 over the whole weight range
      al_round = prod_ff.al + (prod_ff.al >> 8) + AL_BITS'(1);
      sum_in.quo[CH_ALPHA] = al_round[AL_BITS-1:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wgt_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (wgt_ready)  wgt_valid_ff  <= in_valid;
         if (prod_ready) prod_valid_ff <= wgt_valid_ff;
         if (sum_ready)  sum_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wgt_ready && in_valid)       wgt_ff  <= wgt_in;
      if (prod_ready && wgt_valid_ff)  prod_ff <= prod_in;
      if (sum_ready && prod_valid_ff)  sum_ff  <= sum_in;
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

endmodule

// ----- design/apbo_divider.sv -----
// pipelined restoring divider, one quotient bit per stage on the three color lanes
module apbo_divider import apbo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_data_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output div_data_type out_data
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES:0]   stage_ready;
   div_data_type          data_ff [DIV_STAGES];

   assign stage_ready[DIV_STAGES] = out_ready;

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int unsigned BIT = DIV_STAGES - 1 - j;

      logic         src_valid;
      div_data_type src_data;
      div_data_type data_in;

      if (j == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_data  = in_data;
      end else begin : g_next
         assign src_valid = valid_ff[j-1];
         assign src_data  = data_ff[j-1];
      end

      assign stage_ready[j] = !valid_ff[j] || stage_ready[j+1];

      always_comb begin
         logic [NUM_BITS-1:0] shifted;
         data_in = src_data;
         shifted = NUM_BITS'(src_data.al) << BIT;
         for (int l = 0; l < NUM_COLORS; l++) begin
            if (src_data.rem[l] >= shifted) begin
               data_in.rem[l]      = src_data.rem[l] - shifted;
               data_in.quo[l][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (stage_ready[j]) begin
            valid_ff[j] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[j] && src_valid) data_ff[j] <= data_in;
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = data_ff[DIV_STAGES-1];

endmodule

// ----- design/apbo_checker.sv -----
// port-level checks for the pixel blend unit and their bind
module apbo_checker import apbo_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_pixel
);

   logic [4:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) pending_in = pending_ff + 5'd1;
      if (rsp_beat && !req_beat) pending_in = pending_ff - 5'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_pixel))
      else $error("result beat changed while stalled");

   // a free output means every stage can move
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is free");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 5'd0 |-> !rsp_valid)
      else $error("result beat with no item in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 5'(PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

endmodule

bind apng_pixel_blend_over_unit apbo_checker u_apbo_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_pixel (rsp_bus.out_pixel)
);
